### sv/sorted_key_table_assert.svh
// Assertion macros for the sorted key table.
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SKT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sorted_key_table: assertion failed");
`define SKT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sorted_key_table: implication failed");
`else
`define SKT_ASSERT(lbl, clk, rstn, prop)
`define SKT_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

### sv/skt_pkg.sv
`timescale 1ns / 1ps

package skt_pkg;

  localparam int CAPACITY = 8;
  localparam int IDX_W    = 3;
  localparam int CNT_W    = 4;
  localparam int KEY_W    = 27;
  localparam int PAY_W    = 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STS_INSERTED  = 3'd0,
    STS_FULL      = 3'd1,
    STS_REMOVED   = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_ENTRY     = 3'd4,
    STS_EMPTY     = 3'd5
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  typedef struct packed {
    action_e            action;
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [KEY_W-1:0]   entry_key;
    logic [PAY_W-1:0]   entry_payload;
    logic [IDX_W-1:0]   position;
    logic [CNT_W-1:0]   count;
    logic               last;
  } res_t;

  // One stored entry
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;
  } entry_t;

  // Broadcast command to every cell
  typedef struct packed {
    logic               ins;
    logic               del;
    entry_t             ent;
  } cell_ctl_t;

  // Per-cell flags handed along the chain and back to control
  typedef struct packed {
    logic               le;
    logic               seen;
    logic               first;
    logic               take_new;
  } cell_stat_t;

endpackage

### sv/skt_cell.sv
`timescale 1ns / 1ps

module skt_cell (
  input  logic                  clk_i,
  input  skt_pkg::cell_ctl_t    ctl_i,
  input  logic                  occ_i,
  input  logic                  prev_le_i,
  input  logic                  prev_seen_i,
  input  skt_pkg::entry_t       left_i,
  input  skt_pkg::entry_t       right_i,
  output skt_pkg::entry_t       entry_o,
  output skt_pkg::cell_stat_t   stat_o
);

  skt_pkg::entry_t entry_q, entry_d;
  logic            le, match, seen;

  // Compare the held key against the broadcast key
  always_comb begin
    le    = occ_i && (entry_q.key <= ctl_i.ent.key);
    match = occ_i && (entry_q.key == ctl_i.ent.key);
    seen  = prev_seen_i || match;
  end

  // Flags for the neighbor and for control
  always_comb begin
    stat_o.le       = le;
    stat_o.seen     = seen;
    stat_o.first    = match && !prev_seen_i;
    stat_o.take_new = !le && prev_le_i;
  end

  // Take the new entry, shift up from the left, close the gap from the right, or hold
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      if (!le && prev_le_i) begin
        entry_d = ctl_i.ent;
      end else if (!le) begin
        entry_d = left_i;
      end
    end else if (ctl_i.del && seen) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### sv/sorted_key_table.sv
`timescale 1ns / 1ps

// Sorted key table: up to CAPACITY entries kept in ascending key order in a
// row of cells. An insert or cancel gives a single result, which appears on
// the cycle after the transfer; a new command may follow right away. A read
// steps one read port through the cells, one entry per cycle, so it keeps
// busy high until the last entry is read, and each result appears in the
// cycle after its entry is read. An empty read gives one result.
// Results are strobed by result_valid_o for exactly one cycle and must be
// captured then: the receiver cannot stall the block.
module sorted_key_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  skt_pkg::req_t req_i,
  output logic          result_valid_o,
  output skt_pkg::res_t result_o
);

  `include "sorted_key_table_assert.svh"

  skt_pkg::state_e                 state_q, state_d;
  logic [skt_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [skt_pkg::IDX_W-1:0]       idx_q, idx_d;
  skt_pkg::res_t                   res_q, res_d;
  logic                            res_valid_q, res_valid_d;

  skt_pkg::cell_ctl_t              ctl;
  skt_pkg::entry_t                 ent   [skt_pkg::CAPACITY];
  skt_pkg::cell_stat_t             stat  [skt_pkg::CAPACITY];
  logic [skt_pkg::CAPACITY-1:0]    occ;
  logic                            accept, full, found, read_last;
  logic [skt_pkg::IDX_W-1:0]       ins_pos, del_pos;

  assign accept    = start && !busy;
  assign full      = (cnt_q >= skt_pkg::CNT_W'(skt_pkg::CAPACITY));
  assign found     = stat[skt_pkg::CAPACITY-1].seen;
  assign read_last = ((skt_pkg::CNT_W'(idx_q) + skt_pkg::CNT_W'(1)) == cnt_q);

  // Broadcast the command to the row
  always_comb begin
    ctl.ins         = accept && (req_i.action == skt_pkg::ACT_INSERT) && !full;
    ctl.del         = accept && (req_i.action == skt_pkg::ACT_CANCEL);
    ctl.ent.key     = req_i.key;
    ctl.ent.payload = req_i.payload;
  end

  // Build the row of cells
  for (genvar i = 0; i < skt_pkg::CAPACITY; i++) begin : g_cell
    assign occ[i] = (skt_pkg::CNT_W'(i) < cnt_q);
    skt_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occ_i       (occ[i]),
      .prev_le_i   ((i == 0) ? 1'b1 : stat[(i == 0) ? 0 : i-1].le),
      .prev_seen_i ((i == 0) ? 1'b0 : stat[(i == 0) ? 0 : i-1].seen),
      .left_i      (ent[(i == 0) ? 0 : i-1]),
      .right_i     (ent[(i == skt_pkg::CAPACITY-1) ? i : i+1]),
      .entry_o     (ent[i]),
      .stat_o      (stat[i])
    );
  end

  // Encode the one-hot insert and remove slots
  always_comb begin
    ins_pos = '0;
    del_pos = '0;
    for (int i = 0; i < skt_pkg::CAPACITY; i++) begin
      if (stat[i].take_new) ins_pos = ins_pos | skt_pkg::IDX_W'(i);
      if (stat[i].first)    del_pos = del_pos | skt_pkg::IDX_W'(i);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skt_pkg::ST_IDLE: begin
        if (accept && (req_i.action == skt_pkg::ACT_READ) && (cnt_q != '0)) begin
          state_d = skt_pkg::ST_READ;
        end
      end
      skt_pkg::ST_READ: begin
        if (read_last) state_d = skt_pkg::ST_IDLE;
      end
      default: state_d = skt_pkg::ST_IDLE;
    endcase
  end

  // Results, count and read index
  always_comb begin
    cnt_d               = cnt_q;
    idx_d               = idx_q;
    res_valid_d         = 1'b0;
    res_d               = res_q;
    res_d.entry_key     = '0;
    res_d.entry_payload = '0;
    res_d.position      = '0;
    res_d.last          = 1'b1;
    unique case (state_q)
      skt_pkg::ST_IDLE: begin
        idx_d = '0;
        if (accept) begin
          unique case (req_i.action)
            skt_pkg::ACT_INSERT: begin
              res_valid_d = 1'b1;
              if (full) begin
                res_d.status = skt_pkg::STS_FULL;
              end else begin
                cnt_d          = cnt_q + skt_pkg::CNT_W'(1);
                res_d.status   = skt_pkg::STS_INSERTED;
                res_d.position = ins_pos;
              end
            end
            skt_pkg::ACT_CANCEL: begin
              res_valid_d = 1'b1;
              if (found) begin
                cnt_d          = cnt_q - skt_pkg::CNT_W'(1);
                res_d.status   = skt_pkg::STS_REMOVED;
                res_d.position = del_pos;
              end else begin
                res_d.status   = skt_pkg::STS_NOT_FOUND;
              end
            end
            skt_pkg::ACT_READ: begin
              if (cnt_q == '0) begin
                res_valid_d  = 1'b1;
                res_d.status = skt_pkg::STS_EMPTY;
              end
            end
            default: begin
              res_valid_d = 1'b0;
            end
          endcase
        end
        res_d.count = cnt_d;
      end
      skt_pkg::ST_READ: begin
        res_valid_d         = 1'b1;
        res_d.status        = skt_pkg::STS_ENTRY;
        res_d.entry_key     = ent[idx_q].key;
        res_d.entry_payload = ent[idx_q].payload;
        res_d.position      = idx_q;
        res_d.count         = cnt_q;
        res_d.last          = read_last;
        idx_d               = idx_q + skt_pkg::IDX_W'(1);
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skt_pkg::ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy           = (state_q == skt_pkg::ST_READ);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  `SKT_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= skt_pkg::CNT_W'(skt_pkg::CAPACITY))
  `SKT_ASSERT_IMPL(a_read_cnt_stable, clk_i, rst_ni, busy, ##1 $stable(cnt_q))
  `SKT_ASSERT_IMPL(a_cmd_result, clk_i, rst_ni, accept && (req_i.action == skt_pkg::ACT_INSERT || req_i.action == skt_pkg::ACT_CANCEL), ##1 result_valid_o)
  `SKT_ASSERT_IMPL(a_last_frees, clk_i, rst_ni, result_valid_o && result_o.last, !busy)
  `SKT_ASSERT_IMPL(a_read_strobe, clk_i, rst_ni, $past(busy) && busy, result_valid_o && !result_o.last)

endmodule

### dv/sorted_key_table_tb.sv
`timescale 1ns / 1ps

module sorted_key_table_tb;

  localparam int unsigned KEY_MAX     = 99991231;
  localparam int unsigned RANDOM_CMDS = 450;

  // Mirror of the table: predicts every strobe a command causes and checks
  // the strobes in arrival order.
  class key_table_scoreboard;
    logic [skt_pkg::KEY_W-1:0] slot_key [skt_pkg::CAPACITY];
    logic [skt_pkg::PAY_W-1:0] slot_pay [skt_pkg::CAPACITY];
    int unsigned               stored;
    skt_pkg::res_t             pending_results[$];
    int unsigned               mismatches;

    function new();
      stored     = 0;
      mismatches = 0;
    endfunction

    function void push_result(skt_pkg::status_e s, logic [skt_pkg::KEY_W-1:0] k,
                              logic [skt_pkg::PAY_W-1:0] p, int unsigned pos, logic last);
      skt_pkg::res_t r;
      r.status        = s;
      r.entry_key     = k;
      r.entry_payload = p;
      r.position      = pos[skt_pkg::IDX_W-1:0];
      r.count         = stored[skt_pkg::CNT_W-1:0];
      r.last          = last;
      pending_results.push_back(r);
    endfunction

    // Apply one accepted command to the mirror and queue its results
    function void note_command(skt_pkg::req_t cmd);
      int unsigned slot;
      int unsigned j;
      case (cmd.action)
        skt_pkg::ACT_INSERT: begin
          if (stored >= skt_pkg::CAPACITY) begin
            push_result(skt_pkg::STS_FULL, '0, '0, 0, 1'b1);
          end else begin
            // New entry lands after every entry with an equal or smaller key
            slot = 0;
            while (slot < stored && slot_key[slot] <= cmd.key) slot++;
            for (j = stored; j > slot; j--) begin
              slot_key[j] = slot_key[j-1];
              slot_pay[j] = slot_pay[j-1];
            end
            slot_key[slot] = cmd.key;
            slot_pay[slot] = cmd.payload;
            stored++;
            push_result(skt_pkg::STS_INSERTED, '0, '0, slot, 1'b1);
          end
        end
        skt_pkg::ACT_CANCEL: begin
          slot = 0;
          while (slot < stored && slot_key[slot] != cmd.key) slot++;
          if (slot >= stored) begin
            push_result(skt_pkg::STS_NOT_FOUND, '0, '0, 0, 1'b1);
          end else begin
            // Close the gap left by the lowest matching slot
            for (j = slot; j + 1 < stored; j++) begin
              slot_key[j] = slot_key[j+1];
              slot_pay[j] = slot_pay[j+1];
            end
            stored--;
            push_result(skt_pkg::STS_REMOVED, '0, '0, slot, 1'b1);
          end
        end
        skt_pkg::ACT_READ: begin
          if (stored == 0) begin
            push_result(skt_pkg::STS_EMPTY, '0, '0, 0, 1'b1);
          end else begin
            for (j = 0; j < stored; j++)
              push_result(skt_pkg::STS_ENTRY, slot_key[j], slot_pay[j], j, j + 1 == stored);
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      if (mismatches < 100) $display("MISMATCH at %0t ns: %s", $time, what);
      mismatches++;
    endtask

    // Compare one strobed result with the oldest prediction
    task check_result(skt_pkg::res_t got);
      skt_pkg::res_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %p", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.entry_key !== want.entry_key)
        report_mismatch($sformatf("entry_key got %0d want %0d",
                                  got.entry_key, want.entry_key));
      if (got.entry_payload !== want.entry_payload)
        report_mismatch($sformatf("entry_payload got %08h want %08h",
                                  got.entry_payload, want.entry_payload));
      if (got.position !== want.position)
        report_mismatch($sformatf("position got %0d want %0d", got.position, want.position));
      if (got.count !== want.count)
        report_mismatch($sformatf("count got %0d want %0d", got.count, want.count));
      if (got.last !== want.last)
        report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
    endtask
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  skt_pkg::req_t req_i;
  logic          result_valid_o;
  skt_pkg::res_t result_o;

  key_table_scoreboard       sb;
  int unsigned               idle_mode;
  logic [skt_pkg::KEY_W-1:0] date_pool [16];

  sorted_key_table u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Capture every strobed result; the receiver cannot stall the block
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) sb.check_result(result_o);
  end

  function automatic skt_pkg::req_t make_req(skt_pkg::action_e a,
                                             logic [skt_pkg::KEY_W-1:0] k,
                                             logic [skt_pkg::PAY_W-1:0] p);
    skt_pkg::req_t r;
    r.action  = a;
    r.key     = k;
    r.payload = p;
    return r;
  endfunction

  // Idle mode 0: back to back, 1: full random gaps, 2: mostly back to back
  function automatic int unsigned next_gap();
    if (idle_mode == 0) return 0;
    if (idle_mode == 2) return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
    return $urandom_range(0, 14);
  endfunction

  // Hold the command until the block takes it, then note the transfer
  task automatic drive_cmd(skt_pkg::req_t r);
    int unsigned gap;
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_command(r);
  endtask

  // Drop start and wait until every predicted result has come
  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    // Empty table, unused code, extremes of key and payload
    drive_cmd(make_req(skt_pkg::ACT_READ, '0, '0));
    drive_cmd(make_req(skt_pkg::ACT_CANCEL, skt_pkg::KEY_W'(20240101), 32'h1234_5678));
    drive_cmd(make_req(skt_pkg::ACT_NONE, skt_pkg::KEY_W'(20240101), 32'hDEAD_BEEF));
    drive_cmd(make_req(skt_pkg::ACT_INSERT, skt_pkg::KEY_W'(KEY_MAX), 32'hFFFF_FFFF));
    drive_cmd(make_req(skt_pkg::ACT_INSERT, '0, 32'h0000_0000));
    // Equal keys go after the ones already stored
    drive_cmd(make_req(skt_pkg::ACT_INSERT, skt_pkg::KEY_W'(20240315), 32'hA5A5_A5A5));
    drive_cmd(make_req(skt_pkg::ACT_INSERT, skt_pkg::KEY_W'(20240315), 32'h5A5A_5A5A));
    drive_cmd(make_req(skt_pkg::ACT_INSERT, skt_pkg::KEY_W'(20240315), 32'h0000_0001));
    drive_cmd(make_req(skt_pkg::ACT_READ, '0, '0));
    // Cancel takes the lowest matching slot
    drive_cmd(make_req(skt_pkg::ACT_CANCEL, skt_pkg::KEY_W'(20240315), '0));
    drive_cmd(make_req(skt_pkg::ACT_CANCEL, skt_pkg::KEY_W'(12345678), '0));
    // Fill up, then insert into a full table
    drive_cmd(make_req(skt_pkg::ACT_INSERT, skt_pkg::KEY_W'(19991231), 32'h8000_0000));
    drive_cmd(make_req(skt_pkg::ACT_INSERT, skt_pkg::KEY_W'(20000101), 32'h7FFF_FFFF));
    drive_cmd(make_req(skt_pkg::ACT_INSERT, skt_pkg::KEY_W'(KEY_MAX), 32'hCAFE_F00D));
    drive_cmd(make_req(skt_pkg::ACT_INSERT, skt_pkg::KEY_W'(1), 32'h0F0F_0F0F));
    drive_cmd(make_req(skt_pkg::ACT_INSERT, skt_pkg::KEY_W'(55555555), 32'h1111_1111));
    drive_cmd(make_req(skt_pkg::ACT_READ, '0, '0));
    drive_cmd(make_req(skt_pkg::ACT_NONE, skt_pkg::KEY_W'(KEY_MAX), 32'hFFFF_FFFF));
    drive_cmd(make_req(skt_pkg::ACT_CANCEL, skt_pkg::KEY_W'(KEY_MAX), '0));
    drive_cmd(make_req(skt_pkg::ACT_CANCEL, '0, '0));
    drive_cmd(make_req(skt_pkg::ACT_INSERT, skt_pkg::KEY_W'(67108864), 32'h2222_2222));
    drive_cmd(make_req(skt_pkg::ACT_READ, '0, '0));
  endtask

  function automatic logic [skt_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(0, 1) == 0) return date_pool[$urandom_range(0, 15)];
    return skt_pkg::KEY_W'($urandom_range(0, KEY_MAX));
  endfunction

  task automatic run_random();
    int unsigned               issued;
    int unsigned               roll;
    logic [skt_pkg::KEY_W-1:0] k;
    issued = 0;
    while (issued < RANDOM_CMDS) begin
      // Switch idling style every few dozen commands
      if (issued % 40 == 0) idle_mode = $urandom_range(0, 2);
      if (issued == RANDOM_CMDS / 2) drain_results();
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        drive_cmd(make_req(skt_pkg::ACT_NONE, skt_pkg::KEY_W'($urandom_range(0, KEY_MAX)),
                           $urandom()));
      end else begin
        if (roll < 46) begin
          drive_cmd(make_req(skt_pkg::ACT_INSERT, pick_key(), $urandom()));
        end else if (roll < 81) begin
          // Mostly cancel a key that is stored, sometimes a stray one
          if (sb.stored > 0 && $urandom_range(0, 4) != 0)
            k = sb.slot_key[$urandom_range(0, sb.stored - 1)];
          else
            k = pick_key();
          drive_cmd(make_req(skt_pkg::ACT_CANCEL, k, $urandom()));
        end else begin
          drive_cmd(make_req(skt_pkg::ACT_READ, skt_pkg::KEY_W'($urandom_range(0, KEY_MAX)),
                             $urandom()));
        end
        issued++;
      end
    end
  endtask

  initial begin
    sb        = new();
    idle_mode = 1;
    foreach (date_pool[i]) date_pool[i] = skt_pkg::KEY_W'($urandom_range(0, KEY_MAX));
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    // Let the table go quiet before the random traffic
    drain_results();
    run_random();
    start <= 1'b0;

    drain_results();
    repeat (skt_pkg::CAPACITY + 4) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
